>>> rtl/core/pnsf_pkg.sv
// ----------------------------------------------------------------------------
// pnsf_pkg: shared types, constants and helpers of the pink noise filter
// Word types, filter coefficients in Q2.30, the sequencer states, lane
// control and the round / saturate helpers used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pnsf_pkg;

   // field widths
   localparam int SAMPLE_W = 16;           // Q5.11 sample
   localparam int PINK_W   = 24;           // Q4.20 pink sample
   localparam int STATE_W  = 32;           // Q8.24 filter state
   localparam int COEF_W   = 32;           // Q2.30 coefficient
   localparam int NSEC     = 6;            // number of leaky sections
   localparam int NLANE    = NSEC + 2;     // sections plus two scaling lanes

   // serial multiply geometry
   localparam int OP_W   = STATE_W;        // longest serial operand
   localparam int HI_W   = COEF_W + 1;     // upper part of the product register
   localparam int SUM_W  = COEF_W + 2;     // adder width in a lane
   localparam int PROD_W = OP_W + HI_W;    // full product register
   localparam int ACC_W  = STATE_W + 4;    // sum of eight terms
   localparam int DIR_W  = STATE_W + 1;    // direct term
   localparam int CNT_W  = $clog2(OP_W);

   // round positions
   localparam int SH_WHITE = 46;           // 16 serial steps plus 30
   localparam int SH_XS    = 33;           // 16 serial steps plus 17
   localparam int SH_STATE = 30;           // 32 serial steps, Q30 back to Q24
   localparam int SH_PINK  = 4;            // Q8.24 down to Q4.20

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // section coefficients: s = a*s + b*xs
   localparam coef_type SEC_A [NSEC] = '{
      32'sd1072517758, 32'sd1066569229, 32'sd1040455827,
      32'sd930397290,  32'sd590558003,  -32'sd817761773
   };
   localparam coef_type SEC_B [NSEC] = '{
      32'sd59611891,  32'sd80612134,  32'sd165197327,
      32'sd333381374, 32'sd572253067, -32'sd18144089
   };
   localparam coef_type K_WHITE  = 32'sd107374182;   // 0.1
   localparam coef_type K_SCALE  = 32'sd32212255;    // 0.03
   localparam coef_type K_DIRECT = 32'sd575740366;   // 0.5362
   localparam coef_type K_TAP    = 32'sd124474595;   // 0.115926

   // lane slots for the two scaling lanes
   localparam int LANE_WD = NSEC;          // white, then direct term
   localparam int LANE_ST = NSEC + 1;      // scaled input, then tap

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] white_sample;
      logic                       end_of_block;
   } pnsf_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] white_out;
      logic signed [PINK_W-1:0]   pink_out;
      logic                       block_last;
   } pnsf_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_W,
      ST_XS,
      ST_MUL_S,
      ST_ROUND,
      ST_SUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic run;
      logic msb;
   } lane_ctrl_type;

   // round half up: add half an lsb, then arithmetic shift
   function automatic logic signed [PROD_W:0] round_shift(input prod_type p,
                                                          input int unsigned sh);
      logic signed [PROD_W:0] w;
      w = {p[PROD_W-1], p} + ((PROD_W+1)'(1) << (sh - 1));
      return w >>> sh;
   endfunction

   // clamp to an n-bit signed range
   function automatic logic signed [PROD_W:0] sat_to(input logic signed [PROD_W:0] v,
                                                     input int unsigned n);
      logic signed [PROD_W:0] hi_lim;
      logic signed [PROD_W:0] lo_lim;
      hi_lim = ($signed((PROD_W+1)'(1)) <<< (n - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (v > hi_lim) begin
         return hi_lim;
      end else if (v < lo_lim) begin
         return lo_lim;
      end else begin
         return v;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/pnsf_lane.sv
// ----------------------------------------------------------------------------
// pnsf_lane: bit-serial multiply-accumulate lane
// Forms coef1*op1 + coef2*op2 exactly, taking one bit of each operand per
// cycle while run is high, lsb first; the sign bit cycle subtracts instead of adding.
// ----------------------------------------------------------------------------
`default_nettype none

module pnsf_lane import pnsf_pkg::*; (
   input  logic          clock,
   input  lane_ctrl_type ctrl,
   input  logic          op1_bit,
   input  logic          op2_bit,
   input  coef_type      coef1,
   input  coef_type      coef2,
   output prod_type      product
);

   prod_type               prod_ff;
   prod_type               prod_in;
   logic signed [SUM_W-1:0] addend;
   logic signed [SUM_W-1:0] hi;

   // partial product of this bit pair, added at the top and shifted right
   always_comb begin
      addend = '0;
      if (op1_bit) begin
         addend = addend + {{(SUM_W-COEF_W){coef1[COEF_W-1]}}, coef1};
      end
      if (op2_bit) begin
         addend = addend + {{(SUM_W-COEF_W){coef2[COEF_W-1]}}, coef2};
      end
      if (ctrl.msb) begin
         addend = -addend;
      end
      hi      = {prod_ff[PROD_W-1], prod_ff[PROD_W-1:OP_W]} + addend;
      prod_in = {hi, prod_ff[OP_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         prod_ff <= '0;
      end else if (ctrl.run) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

>>> rtl/core/pink_noise_shaping_filter.sv
// ----------------------------------------------------------------------------
// pink_noise_shaping_filter: refined pink noise filter, fixed point
// One white sample in, one word out with the sample times 0.1 and the pink
// sample from six leaky sections, a delayed tap and a direct term.
// ----------------------------------------------------------------------------
// A word is taken at the end of an idle cycle, and its result is written to
// the output register after these steps: a bit-serial multiply over the
// input sample (white and 0.03 scaling), a round, a bit-serial multiply over
// the 32-bit section state and scaled sample, all eight lanes in parallel,
// a second round, the sum of the terms added one per cycle, and the write
// of the result. The serial multiplies set the pace. No new word is taken
// while a word is in work. A new word is taken in the cycle after the result
// has moved to the output register, even while that result waits for the
// consumer; the result is written as soon as the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pink_noise_shaping_filter import pnsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pnsf_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pnsf_rsp_type rsp_word
);

   localparam logic [CNT_W-1:0] W_LAST   = CNT_W'(SAMPLE_W - 1);
   localparam logic [CNT_W-1:0] S_LAST   = CNT_W'(OP_W - 1);
   localparam logic [CNT_W-1:0] SUM_LAST = CNT_W'(NLANE - 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   accept;
   logic                   rsp_load;
   lane_ctrl_type          lane_ctrl;

   logic signed [SAMPLE_W-1:0] w_ff;
   logic                       eob_ff;
   logic signed [STATE_W-1:0]  xs_ff;
   logic signed [SAMPLE_W-1:0] white_ff;
   logic signed [STATE_W-1:0]  section_ff [NSEC];
   logic signed [STATE_W-1:0]  tap_ff;
   logic signed [STATE_W-1:0]  tap_next_ff;
   logic signed [DIR_W-1:0]    direct_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       rsp_valid_ff;
   pnsf_rsp_type               rsp_word_ff;

   logic     op1_bit [NLANE];
   logic     op2_bit [NLANE];
   coef_type coef1   [NLANE];
   coef_type coef2   [NLANE];
   prod_type product [NLANE];

   logic signed [PROD_W:0]     white_wide, xs_wide, tap_wide, direct_wide, pink_wide;
   logic signed [PROD_W:0]     sec_wide [NSEC];
   logic signed [ACC_W-1:0]    sum_term;
   logic [2:0]                 sum_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid)                      state_in = ST_MUL_W;
         ST_MUL_W:  if (cnt_ff == W_LAST)               state_in = ST_XS;
         ST_XS:                                         state_in = ST_MUL_S;
         ST_MUL_S:  if (cnt_ff == S_LAST)               state_in = ST_ROUND;
         ST_ROUND:                                      state_in = ST_SUM;
         ST_SUM:    if (cnt_ff == SUM_LAST)             state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || !rsp_stall)    state_in = ST_IDLE;
         default:                                       state_in = ST_IDLE;
      endcase
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
   end

   // sequencer outputs
   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      accept          = (state_ff == ST_IDLE) && req_valid;
      rsp_load        = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
      lane_ctrl.clear = accept || (state_ff == ST_XS);
      lane_ctrl.run   = (state_ff == ST_MUL_W) || (state_ff == ST_MUL_S);
      lane_ctrl.msb   = ((state_ff == ST_MUL_W) && (cnt_ff == W_LAST)) ||
                        ((state_ff == ST_MUL_S) && (cnt_ff == S_LAST));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // lane operands: sections, then the white / direct and scale / tap lanes
   always_comb begin
      for (int i = 0; i < NSEC; i++) begin
         op1_bit[i] = (state_ff == ST_MUL_S) && section_ff[i][0];
         op2_bit[i] = (state_ff == ST_MUL_S) && xs_ff[0];
         coef1[i]   = SEC_A[i];
         coef2[i]   = SEC_B[i];
      end
      op1_bit[LANE_WD] = (state_ff == ST_MUL_W) && w_ff[0];
      op2_bit[LANE_WD] = (state_ff == ST_MUL_S) && xs_ff[0];
      coef1[LANE_WD]   = K_WHITE;
      coef2[LANE_WD]   = K_DIRECT;
      op1_bit[LANE_ST] = (state_ff == ST_MUL_W) && w_ff[0];
      op2_bit[LANE_ST] = (state_ff == ST_MUL_S) && xs_ff[0];
      coef1[LANE_ST]   = K_SCALE;
      coef2[LANE_ST]   = K_TAP;
   end

   for (genvar g = 0; g < NLANE; g++) begin : g_lane
      pnsf_lane u_lane (
         .clock   (clock),
         .ctrl    (lane_ctrl),
         .op1_bit (op1_bit[g]),
         .op2_bit (op2_bit[g]),
         .coef1   (coef1[g]),
         .coef2   (coef2[g]),
         .product (product[g])
      );
   end

   // rounding of lane products
   always_comb begin
      white_wide  = sat_to(round_shift(product[LANE_WD], SH_WHITE), SAMPLE_W);
      xs_wide     = sat_to(round_shift(product[LANE_ST], SH_XS), STATE_W);
      direct_wide = round_shift(product[LANE_WD], SH_STATE);
      tap_wide    = sat_to(round_shift(product[LANE_ST], SH_STATE), STATE_W);
      for (int i = 0; i < NSEC; i++) begin
         sec_wide[i] = sat_to(round_shift(product[i], SH_STATE), STATE_W);
      end
   end

   // term picked for the serial sum
   always_comb begin
      sum_idx = cnt_ff[2:0];
      case (sum_idx)
         3'(LANE_WD): sum_term = ACC_W'(tap_ff);
         3'(LANE_ST): sum_term = ACC_W'(direct_ff);
         default:     sum_term = ACC_W'(section_ff[sum_idx]);
      endcase
      pink_wide = sat_to(round_shift(PROD_W'(acc_ff), SH_PINK), PINK_W);
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSEC; i++) begin
            section_ff[i] <= '0;
         end
         tap_ff <= '0;
      end else begin
         if (state_ff == ST_MUL_S) begin
            for (int i = 0; i < NSEC; i++) begin
               section_ff[i] <= {section_ff[i][0], section_ff[i][STATE_W-1:1]};
            end
         end else if (state_ff == ST_ROUND) begin
            for (int i = 0; i < NSEC; i++) begin
               section_ff[i] <= sec_wide[i][STATE_W-1:0];
            end
         end
         if (rsp_load) begin
            tap_ff <= tap_next_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff   <= req_word.white_sample;
         eob_ff <= req_word.end_of_block;
      end else if (state_ff == ST_MUL_W) begin
         w_ff <= {w_ff[0], w_ff[SAMPLE_W-1:1]};
      end
      if (state_ff == ST_XS) begin
         xs_ff    <= xs_wide[STATE_W-1:0];
         white_ff <= white_wide[SAMPLE_W-1:0];
      end else if (state_ff == ST_MUL_S) begin
         xs_ff <= {xs_ff[0], xs_ff[STATE_W-1:1]};
      end
      if (state_ff == ST_ROUND) begin
         tap_next_ff <= tap_wide[STATE_W-1:0];
         direct_ff   <= direct_wide[DIR_W-1:0];
         acc_ff      <= '0;
      end else if (state_ff == ST_SUM) begin
         acc_ff <= acc_ff + sum_term;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff.white_out  <= white_ff;
         rsp_word_ff.pink_out   <= pink_wide[PINK_W-1:0];
         rsp_word_ff.block_last <= eob_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

>>> rtl/core/pnsf_checker.sv
// ----------------------------------------------------------------------------
// pnsf_port_checker: port-level checks of the pink noise filter
// Watches the handshakes of the top level and the spacing between a word
// taken in and the result that it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module pnsf_port_checker import pnsf_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input pnsf_req_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input pnsf_rsp_type rsp_word
);

   // a stalled input word stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("input word changed while stalled");

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // a taken word keeps the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after a word");

   // no result appears right after a word is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too soon after input");

   // a fresh result leaves the block ready for the next word
   a_ready_on_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("block busy when a result was written");

endmodule

bind pink_noise_shaping_filter pnsf_port_checker u_pnsf_port_checker (.*);

`default_nettype wire

>>> tb/pnsf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pnsf_checker: prediction and comparison for the pink noise filter
// Watches both channels of the block. Every accepted sample word is run
// through a bit-true fixed point model of the six leaky sections, the
// delayed tap and the direct term. The predicted result word is queued, and
// each accepted result word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module pnsf_checker import pnsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  pnsf_req_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  pnsf_rsp_type rsp_word,
   output int           error_count,
   output int           words_pending
);

   localparam int MAX_REPORTS = 50;

   // q2.30 gains of the scaling lanes
   localparam longint WHITE_GAIN  = 64'sd107374182;    // 0.1
   localparam longint INPUT_SCALE = 64'sd32212255;     // 0.03
   localparam longint DIRECT_GAIN = 64'sd575740366;    // 0.5362
   localparam longint TAP_GAIN    = 64'sd124474595;    // 0.115926

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   logic signed [31:0] section_state [6];
   logic signed [31:0] tap_state;
   pnsf_rsp_type       expected_words [$];
   int                 errors_seen = 0;

   // pole coefficient of each leaky section, q2.30
   function automatic longint leak_coef(input int idx);
      case (idx)
         0:       return 64'sd1072517758;
         1:       return 64'sd1066569229;
         2:       return 64'sd1040455827;
         3:       return 64'sd930397290;
         4:       return 64'sd590558003;
         default: return -64'sd817761773;
      endcase
   endfunction

   // drive coefficient of each leaky section, q2.30
   function automatic longint drive_coef(input int idx);
      case (idx)
         0:       return 64'sd59611891;
         1:       return 64'sd80612134;
         2:       return 64'sd165197327;
         3:       return 64'sd333381374;
         4:       return 64'sd572253067;
         default: return -64'sd18144089;
      endcase
   endfunction

   // add half an lsb, then floor shift
   function automatic longint round_half_up(input longint v, input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // advance the filter state by one sample and form the result word
   function automatic pnsf_rsp_type shape_sample(input pnsf_req_type w);
      pnsf_rsp_type r;
      longint       smp;
      longint       xs;
      longint       prod;
      longint       total;
      longint       white;
      longint       pink;
      smp   = longint'($signed(w.white_sample));
      white = clamp(round_half_up(smp * WHITE_GAIN, 30), -64'sd32768, 64'sd32767);
      xs    = clamp(round_half_up(smp * INPUT_SCALE, 17), S32_MIN, S32_MAX);
      total = 0;
      for (int i = 0; i < 6; i++) begin
         prod = leak_coef(i) * longint'(section_state[i]) + drive_coef(i) * xs;
         section_state[i] = 32'(clamp(round_half_up(prod, 30), S32_MIN, S32_MAX));
         total += longint'(section_state[i]);
      end
      // old tap goes into this sum, new tap is loaded afterwards
      total += longint'(tap_state);
      total += round_half_up(xs * DIRECT_GAIN, 30);
      tap_state = 32'(clamp(round_half_up(xs * TAP_GAIN, 30), S32_MIN, S32_MAX));
      pink = clamp(round_half_up(total, 4), -64'sd8388608, 64'sd8388607);
      r.white_out  = 16'(white);
      r.pink_out   = 24'(pink);
      r.block_last = w.end_of_block;
      return r;
   endfunction

   task automatic note_mismatch(input string field, input longint want, input longint got);
      errors_seen++;
      if (errors_seen <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // compare result words, then queue the prediction for a new sample word
   always @(posedge clock) begin : watch
      pnsf_rsp_type want;
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            section_state[i] = '0;
         end
         tap_state = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               errors_seen++;
               if (errors_seen <= MAX_REPORTS) begin
                  $display("%0t: unexpected word, expected none, actual %0d %0d %0d", $time,
                           rsp_word.white_out, rsp_word.pink_out, rsp_word.block_last);
               end
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.white_out !== want.white_out) begin
                  note_mismatch("white_out", longint'(want.white_out),
                                longint'(rsp_word.white_out));
               end
               if (rsp_word.pink_out !== want.pink_out) begin
                  note_mismatch("pink_out", longint'(want.pink_out),
                                longint'(rsp_word.pink_out));
               end
               if (rsp_word.block_last !== want.block_last) begin
                  note_mismatch("block_last", longint'(want.block_last),
                                longint'(rsp_word.block_last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(shape_sample(req_word));
         end
      end
      words_pending <= expected_words.size();
      error_count   <= errors_seen;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the pink noise shaping filter
// Sends directed sample words, then segments of random noise, quiet noise,
// steady levels, alternating levels and zeros, in bursts with random gaps, while
// the result side stalls on its own pattern. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
   import pnsf_pkg::*;

   localparam int RANDOM_WORDS = 1500;
   // worst word: block busy time, the longest gap and the longest stall,
   // over about 1525 words, then taken about four times over
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;

   typedef enum int {SEG_NOISE, SEG_QUIET, SEG_DC, SEG_ALTERNATE, SEG_ZERO} segment_type;
   typedef enum int {STALL_NONE, STALL_COIN, STALL_LONG} stall_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pnsf_req_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pnsf_rsp_type rsp_word;

   int        error_count;
   int        words_pending;
   int        cycle_count = 0;
   int        burst_left  = 0;
   stall_type stall_mode  = STALL_NONE;
   int        mode_left   = 0;
   int        hold_left   = 0;

   always #10 clock = ~clock;

   pink_noise_shaping_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   pnsf_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   // present one sample word, hold it until taken, then maybe pause
   task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic eob);
      pnsf_req_type w;
      int           gap;
      w.white_sample = smp;
      w.end_of_block = eob;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         burst_left = $urandom_range(0, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // result side stall pattern, changing character when its mode count runs out
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_type'($urandom_range(0, 2));
         mode_left  = $urandom_range(100, 1500);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_COIN: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            if (hold_left > 0) begin
               hold_left--;
            end else begin
               rsp_stall <= ~rsp_stall;
               hold_left = $urandom_range(0, 80);
            end
         end
      endcase
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      segment_type                seg;
      int                         seg_len;
      int                         sent;
      logic signed [SAMPLE_W-1:0] level;
      logic signed [SAMPLE_W-1:0] smp;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // field extremes and bit patterns
      send_word(16'sd0, 1'b0);
      send_word(16'sd1, 1'b0);
      send_word(-16'sd1, 1'b0);
      send_word(16'sh7fff, 1'b1);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh5555, 1'b0);
      send_word(16'shaaaa, 1'b1);
      // full scale steps and a burst of alternation
      for (int k = 0; k < 6; k++) begin
         send_word(16'sh7fff, 1'b0);
      end
      for (int k = 0; k < 6; k++) begin
         send_word(16'sh8000, 1'b0);
      end
      for (int k = 0; k < 4; k++) begin
         send_word(k[0] ? 16'sh8000 : 16'sh7fff, 1'b0);
      end
      send_word(16'sd0, 1'b0);
      send_word(16'sd0, 1'b1);

      // random segments; long steady levels drive the pink sum into saturation
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         seg     = segment_type'($urandom_range(0, 4));
         seg_len = (seg == SEG_DC) ? $urandom_range(50, 300) : $urandom_range(10, 100);
         if ($urandom_range(0, 1) == 1) begin
            level = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
         end else begin
            level = 16'($urandom);
         end
         for (int k = 0; k < seg_len && sent < RANDOM_WORDS; k++) begin
            case (seg)
               SEG_NOISE:     smp = 16'($urandom);
               SEG_QUIET:     smp = 16'($urandom_range(0, 511)) - 16'sd256;
               SEG_DC:        smp = level;
               SEG_ALTERNATE: smp = k[0] ? level : ~level;
               default:       smp = '0;
            endcase
            send_word(smp, (k == seg_len - 1) || ($urandom_range(0, 15) == 0));
            sent++;
         end
      end
      req_valid <= 1'b0;

      // let the pending count see the last word taken
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/pnsf_pkg.sv
rtl/core/pnsf_lane.sv
rtl/core/pink_noise_shaping_filter.sv
rtl/core/pnsf_checker.sv
tb/pnsf_checker.sv
tb/tb_top.sv
